[hdl/shah_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Beat types, hash constants and the round-constant table.
// ----------------------------------------------------------------------------
`default_nettype none

package shah_pkg;

    // Input beat: one message byte plus flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_beat;

    // Output beat: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    // Chaining value, word 0 in the top slice
    typedef logic [7:0][31:0] t_chain;

    // Commands from the byte sequencer to the compression core
    typedef struct packed {
        logic start;
        logic init;
    } t_core_cmd;

    localparam int  BLOCK_BYTES = 64;
    localparam int  BLOCK_BITS  = 8 * BLOCK_BYTES;
    localparam int  ROUNDS      = 64;
    localparam int  COUNT_W     = 61;
    localparam int  LEN_W       = 64;

    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [2:0] LAST_WORD = 3'd7;

    localparam t_chain INIT_VALUE = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

[hdl/shah_chan.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher stream channel
// Valid/ready channel carrying one typed payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface shah_chan #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/shah_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One round per cycle over a 16-word schedule window, then a fold into the
// chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module shah_core (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire shah_pkg::t_core_cmd  i_cmd,
    input  wire [shah_pkg::BLOCK_BITS-1:0] i_block,
    output logic                      o_done,
    output shah_pkg::t_chain          o_chain
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0]     r_win [16];
    logic [31:0]     r_v   [8];
    shah_pkg::t_chain r_chain;
    logic [5:0]      r_round;
    logic            r_run;
    logic            r_fold;
    logic            r_done;

    logic [31:0] w_new, s0, s1, big0, big1, choose, major, t1, t2;

    // Extend the schedule and evaluate one round
    always_comb begin
        s0     = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        s1     = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        w_new  = r_win[0] + s0 + r_win[9] + s1;
        big1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        choose = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1     = r_v[7] + big1 + choose + shah_pkg::ROUND_K[r_round] + r_win[0];
        big0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        major  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2     = big0 + major;
    end

    // Sequence load, rounds and fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= shah_pkg::INIT_VALUE;
            r_run   <= 1'b0;
            r_fold  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.init) begin
                r_chain <= shah_pkg::INIT_VALUE;
            end
            if (i_cmd.start) begin
                for (int i = 0; i < 16; i++) begin
                    r_win[i] <= i_block[shah_pkg::BLOCK_BITS-1-32*i -: 32];
                end
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_chain[7-i];
                end
                r_round <= '0;
                r_run   <= 1'b1;
            end else if (r_run) begin
                for (int i = 0; i < 15; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_round <= r_round + 6'd1;
                if (r_round == shah_pkg::LAST_POS) begin
                    r_run  <= 1'b0;
                    r_fold <= 1'b1;
                end
            end else if (r_fold) begin
                // Fold the working variables into the chaining value
                for (int i = 0; i < 8; i++) begin
                    r_chain[7-i] <= r_chain[7-i] + r_v[i];
                end
                r_fold <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done  = r_done;
    assign o_chain = r_chain;

endmodule

`default_nettype wire

[hdl/sha256_message_hasher.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-wide message in, eight 32-bit digest words out.
// ----------------------------------------------------------------------------
// The hasher takes one message byte per beat while it gathers a block, and
// drops ready while a block is compressed. Compression runs one round per
// cycle in a single shared round unit, so input is held off while each
// 64-byte block is compressed. A beat with the end flag starts padding:
// the pad mark, zeros and the 64-bit bit length are shifted into the block
// one byte per cycle, followed by one or two compressions, then eight
// digest beats go out from a registered output stage. The hasher takes the
// next message's bytes while the last digest word still waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher (
    input  wire     i_clk,
    input  wire     i_rst_n,
    shah_chan.sink   i_msg,
    shah_chan.source o_dig
);

    typedef enum logic [1:0] {S_FILL, S_COMP, S_PAD, S_OUT} t_state;

    t_state                           r_state;
    logic [shah_pkg::BLOCK_BITS-1:0]  r_block;
    logic [5:0]                       r_fill;
    logic [shah_pkg::COUNT_W-1:0]     r_count;
    logic [shah_pkg::LEN_W-1:0]       r_len_sh;
    logic                             r_padding;
    logic                             r_pad_first;
    logic                             r_len_here;
    logic                             r_end_pending;
    logic [2:0]                       r_oidx;
    shah_pkg::t_core_cmd              r_cmd;
    logic                             r_out_valid;
    shah_pkg::t_out_beat              r_out;

    logic             core_done;
    shah_pkg::t_chain core_chain;
    logic [7:0]       pad_byte;
    shah_pkg::t_in_beat in_beat;

    shah_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .i_block (r_block),
        .o_done  (core_done),
        .o_chain (core_chain)
    );

    assign in_beat     = i_msg.payload;
    assign i_msg.ready = (r_state == S_FILL);
    assign o_dig.valid   = r_out_valid;
    assign o_dig.payload = r_out;

    // Pick the next padding byte: mark, zero or length
    always_comb begin
        if (r_pad_first) begin
            pad_byte = shah_pkg::PAD_MARK;
        end else if (r_len_here && (r_fill >= shah_pkg::LEN_POS)) begin
            pad_byte = r_len_sh[shah_pkg::LEN_W-1 -: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Sequence gathering, padding, compression and digest beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_fill        <= '0;
            r_count       <= '0;
            r_padding     <= 1'b0;
            r_pad_first   <= 1'b0;
            r_len_here    <= 1'b0;
            r_end_pending <= 1'b0;
            r_oidx        <= '0;
            r_cmd         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_cmd <= '0;
            if (o_dig.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (i_msg.valid) begin
                        if (in_beat.has_byte) begin
                            r_block <= {r_block[shah_pkg::BLOCK_BITS-9:0], in_beat.data_byte};
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + (shah_pkg::COUNT_W)'(1);
                        end
                        if (in_beat.has_byte && (r_fill == shah_pkg::LAST_POS)) begin
                            // Block full: compress before any padding
                            r_cmd.start   <= 1'b1;
                            r_end_pending <= in_beat.end_of_message;
                            r_state       <= S_COMP;
                        end else if (in_beat.end_of_message) begin
                            r_padding   <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_state     <= S_PAD;
                        end
                    end
                end
                S_COMP: begin
                    if (core_done) begin
                        if (r_padding) begin
                            if (r_len_here) begin
                                r_padding <= 1'b0;
                                r_state   <= S_OUT;
                            end else begin
                                // Length goes into a second pad block
                                r_len_here <= 1'b1;
                                r_state    <= S_PAD;
                            end
                        end else if (r_end_pending) begin
                            r_end_pending <= 1'b0;
                            r_padding     <= 1'b1;
                            r_pad_first   <= 1'b1;
                            r_state       <= S_PAD;
                        end else begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_PAD: begin
                    r_block <= {r_block[shah_pkg::BLOCK_BITS-9:0], pad_byte};
                    r_fill  <= r_fill + 6'd1;
                    if (r_pad_first) begin
                        // Capture bit length and restart the byte count
                        r_pad_first <= 1'b0;
                        r_len_here  <= (r_fill < shah_pkg::LEN_POS);
                        r_len_sh    <= {r_count, 3'b000};
                        r_count     <= '0;
                    end else if (r_len_here && (r_fill >= shah_pkg::LEN_POS)) begin
                        r_len_sh <= {r_len_sh[shah_pkg::LEN_W-9:0], 8'h00};
                    end
                    if (r_fill == shah_pkg::LAST_POS) begin
                        r_cmd.start <= 1'b1;
                        r_state     <= S_COMP;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_dig.ready) begin
                        r_out.digest_word <= core_chain[3'd7 - r_oidx];
                        r_out.word_index  <= r_oidx;
                        r_out.last_word   <= (r_oidx == shah_pkg::LAST_WORD);
                        r_out_valid       <= 1'b1;
                        r_oidx            <= r_oidx + 3'd1;
                        if (r_oidx == shah_pkg::LAST_WORD) begin
                            r_cmd.init <= 1'b1;
                            r_state    <= S_FILL;
                        end
                    end
                end
                default: begin
                    r_state <= S_FILL;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
